// ===== rtl/core/eid_pkg.sv =====
// ----------------------------------------------------------------------------
// eid_pkg
// Shared types and constants for the escaped integer decoder.
// ----------------------------------------------------------------------------
package eid_pkg;

    // Default cap on words per message.
    localparam int COUNT_LIMIT_DEF = 128;

    // Reset value of the max_count register.
    localparam logic [7:0] MAX_COUNT_RST = 8'd128;

    // Decoder phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ESC   = 2'd1;
    localparam logic [1:0] PH_MULTI = 2'd2;
    localparam logic [1:0] PH_MESC  = 2'd3;

    // Byte codes of the escape scheme
    localparam logic [7:0] TERM_BYTE  = 8'd0;
    localparam logic [7:0] ESC_BYTE   = 8'd255;
    localparam logic [7:0] CODE_ZERO  = 8'd1;
    localparam logic [7:0] CODE_SHORT = 8'd254;
    localparam logic [7:0] CODE_LONG  = 8'd253;

    // Byte counts of the multi-byte words
    localparam logic [2:0] SHORT_LEN = 3'd2;
    localparam logic [2:0] LONG_LEN  = 3'd4;

    // One decoded result
    typedef struct packed {
        logic [31:0] word_value;
        logic [6:0]  word_index;
        logic        bad_code;
        logic        end_of_message;
        logic [7:0]  word_count;
    } eid_result_t;

endpackage

// ===== rtl/core/eid_in_stage.sv =====
// ----------------------------------------------------------------------------
// eid_in_stage
// Input register: holds one byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module eid_in_stage
    import eid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,        // decode stage consumes the held byte
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       accept;

    // room when empty or when the held byte leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign accept     = s_tvalid && s_tready;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// ===== rtl/core/eid_core.sv =====
// ----------------------------------------------------------------------------
// eid_core
// Decode state and single-pass next-state logic for one byte.
// ----------------------------------------------------------------------------
module eid_core
    import eid_pkg::*;
#(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        fire,       // byte in b is processed this cycle
    input  logic [7:0]  b,
    output logic        res_valid,
    output eid_result_t res
);

    localparam logic [7:0] LIMIT_CAP =
        (COUNT_LIMIT > 255) ? 8'd255 : 8'(COUNT_LIMIT);

    logic [7:0]  max_count_reg;
    logic [1:0]  phase_reg,   phase_next;
    logic [31:0] acc_reg,     acc_next;
    logic [2:0]  rem_reg,     rem_next;
    logic [7:0]  seen_reg,    seen_next;
    logic        disc_reg,    disc_next;

    logic [7:0]  limit;
    logic [31:0] acc_shift;
    logic [2:0]  rem_dec;
    logic [7:0]  shift_byte;

    // effective word limit
    assign limit = (max_count_reg < LIMIT_CAP) ? max_count_reg : LIMIT_CAP;

    // byte shifted in inside a multi-byte word
    always_comb begin
        if (phase_reg == PH_MESC && b == CODE_ZERO) begin
            shift_byte = 8'd0;
        end else begin
            shift_byte = b;
        end
    end
    assign acc_shift = {acc_reg[23:0], shift_byte};
    assign rem_dec   = (rem_reg != 3'd0) ? rem_reg - 3'd1 : 3'd0;

    // next state and result
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        seen_next  = seen_reg;
        disc_next  = disc_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.word_index = seen_reg[6:0];

        if (b == TERM_BYTE) begin
            // terminator: plain close in idle, broken word otherwise
            res_valid          = 1'b1;
            res.end_of_message = 1'b1;
            if (phase_reg == PH_IDLE) begin
                res.word_index = 7'd0;
                res.word_count = seen_reg;
            end else begin
                res.word_value = '1;
                res.bad_code   = 1'b1;
                res.word_count = seen_reg + 8'd1;
            end
            phase_next = PH_IDLE;
            acc_next   = '0;
            rem_next   = '0;
            seen_next  = '0;
            disc_next  = 1'b0;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (disc_reg || seen_reg >= limit) begin
                        disc_next = 1'b1;
                    end else if (b == ESC_BYTE) begin
                        phase_next = PH_ESC;
                    end else begin
                        res_valid      = 1'b1;
                        res.word_value = {24'd0, b} - 32'd1;
                    end
                end
                PH_ESC: begin
                    if (b == CODE_SHORT || b == CODE_LONG) begin
                        phase_next = PH_MULTI;
                        acc_next   = '0;
                        rem_next   = (b == CODE_SHORT) ? SHORT_LEN : LONG_LEN;
                    end else begin
                        res_valid = 1'b1;
                        if (b == ESC_BYTE) begin
                            res.word_value = {24'd0, ESC_BYTE} - 32'd1;
                        end else if (b == CODE_ZERO) begin
                            res.word_value = '1;
                        end else begin
                            res.word_value = '1;
                            res.bad_code   = 1'b1;
                        end
                    end
                end
                PH_MULTI: begin
                    if (b == ESC_BYTE) begin
                        phase_next = PH_MESC;
                    end else if (rem_dec == 3'd0) begin
                        res_valid      = 1'b1;
                        res.word_value = acc_shift - 32'd1;
                    end else begin
                        phase_next = PH_MULTI;
                        acc_next   = acc_shift;
                        rem_next   = rem_dec;
                    end
                end
                default: begin
                    // escape inside a multi-byte word
                    if (b == ESC_BYTE || b == CODE_ZERO) begin
                        if (rem_dec == 3'd0) begin
                            res_valid      = 1'b1;
                            res.word_value = acc_shift - 32'd1;
                        end else begin
                            phase_next = PH_MULTI;
                            acc_next   = acc_shift;
                            rem_next   = rem_dec;
                        end
                    end else begin
                        res_valid      = 1'b1;
                        res.word_value = '1;
                        res.bad_code   = 1'b1;
                    end
                end
            endcase

            // any emitted word returns to idle and counts
            if (res_valid) begin
                phase_next = PH_IDLE;
                acc_next   = '0;
                rem_next   = '0;
                seen_next  = seen_reg + 8'd1;
            end
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_count_reg <= MAX_COUNT_RST;
        end else if (cfg_we) begin
            max_count_reg <= cfg_wdata;
        end
    end

    // decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            rem_reg   <= '0;
            seen_reg  <= '0;
            disc_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            seen_reg  <= seen_next;
            disc_reg  <= disc_next;
        end
    end

    // byte count is live only inside a multi-byte word
    a_rem_in_multi: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg != 3'd0 |-> (phase_reg == PH_MULTI || phase_reg == PH_MESC))
        else $error("bytes remaining outside a multi-byte word");

    // dropping bytes only happens from idle
    a_disc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        disc_reg |-> phase_reg == PH_IDLE)
        else $error("discarding while not idle");

    // accumulator is clean while waiting for an escape code
    a_esc_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ESC |-> acc_reg == 32'd0)
        else $error("accumulator not clear after escape");

    // closing a message resets the message state
    a_eom_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid && res.end_of_message |=>
            phase_reg == PH_IDLE && seen_reg == 8'd0 && !disc_reg)
        else $error("message state not cleared after terminator");

endmodule

// ===== rtl/core/eid_out_stage.sv =====
// ----------------------------------------------------------------------------
// eid_out_stage
// Result register feeding the master-side stream.
// ----------------------------------------------------------------------------
module eid_out_stage
    import eid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  eid_result_t res,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg;
    eid_result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, res_reg.word_count, res_reg.word_index, res_reg.word_value};
    assign m_tuser  = res_reg.bad_code;
    assign m_tlast  = res_reg.end_of_message;

endmodule

// ===== rtl/core/escaped_integer_decoder.sv =====
// ----------------------------------------------------------------------------
// escaped_integer_decoder
// Byte-stream decoder for escape-coded, zero-terminated integer strings.
// ----------------------------------------------------------------------------
// One byte enters per transfer on the s_ channel. Each nonzero byte either
// completes a word, which leaves as one transfer on the m_ channel, or leaves
// nothing: it only advances the escape state or is dropped. A zero byte
// closes the message with a transfer that has m_tlast set and the word count
// in tdata. Words beyond min(max_count, COUNT_LIMIT) in one message are
// dropped until the terminator. Throughput: one byte per cycle unless the
// receiver stalls; every byte, with or without a result, takes one pass
// through the decode stage. Each byte is held first in the input register,
// and its result then in the result register, which drives m_tvalid. If the
// receiver stalls, the held result waits in the result register while one
// more byte waits in the input register; s_tready then drops.
// Reset (aresetn low, synchronous) empties both registers, returns the
// decoder to idle with no words counted and sets max_count to 128.
// cfg_we writes max_count from cfg_wdata; write it only between messages.
// ----------------------------------------------------------------------------
module escaped_integer_decoder
    import eid_pkg::*;
#(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] word_value, [38:32] word_index,
                                   // [46:39] word_count, [47] zero
    output logic [0:0]  m_tuser,   // [0] bad_code
    output logic        m_tlast    // end_of_message
);

    logic        held_valid;
    logic [7:0]  held_byte;
    logic        fire;
    logic        res_valid;
    eid_result_t res;

    // decode a held byte when the result register can take its output
    assign fire = held_valid && (!m_tvalid || m_tready);

    eid_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (fire),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    eid_core #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .b         (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    eid_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && res_valid),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
